/* design/mgts_pkg.sv */
// Shared types, register codes and blend arithmetic of the staggered-grid sampler.
package mgts_pkg;

    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_INV_X    = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_INV_Y    = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_INV_Z    = 3'd5;

    localparam logic [0:0] REQ_WRITE  = 1'b0;
    localparam logic [0:0] REQ_SAMPLE = 1'b1;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LAT,
        S_RD,
        S_WAIT,
        S_Y0,
        S_Y1,
        S_Z
    } state_t;

    // per-lane sequencing strobes
    typedef struct packed {
        logic       rd;
        logic [2:0] corner;
        logic       y0;
        logic       y1;
        logic       z;
    } lane_ctl_t;

    // a*(1-f) + b*f rounded to Q16.16, written as a + round((b-a)*f)
    function automatic logic signed [33:0] lerp(logic signed [33:0] a,
                                                logic signed [33:0] b,
                                                logic [15:0] f);
        logic signed [34:0] diff;
        logic signed [51:0] prod;
        logic signed [51:0] rnd;
        diff = 35'(b) - 35'(a);
        prod = 52'(diff) * 52'($signed({1'b0, f}));
        rnd  = prod + 52'sd32768;
        return a + 34'(rnd >>> 16);
    endfunction

endpackage

/* design/mac_grid_trilinear_sampler.sv */
// Top level of the periodic staggered-grid trilinear velocity sampler.
//
// Three face stores (x, y, z faces) of CELLS_X*CELLS_Y*CELLS_Z signed Q16.16 words,
// cell (i,j,k) at i + CELLS_X*(j + CELLS_Y*k). A word taken with start high and
// busy low is either a write (req_type 0: at most one cell of one store, done in
// the accept cycle, busy never rises, no result) or a sample (req_type 1). A sample
// runs from accept to the result in these steps: a multiply step, a lattice step,
// eight corner reads (each store has a single read port, read one corner per
// cycle, all three stores in parallel), a read-latency step, two y blends and
// one z blend. The result shows for exactly one cycle with done high;
// busy is already low then, so the next word can be taken in that cycle. Stores
// are not cleared; sample only cells that were written. Configuration through
// cfg_en/cfg_index/cfg_data while idle.
module mac_grid_trilinear_sampler
    import mgts_pkg::*;
#(
    parameter int CELLS_X = 16,
    parameter int CELLS_Y = 16,
    parameter int CELLS_Z = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_en,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 start,
    output logic                 busy,
    input  logic                 req_type,
    input  logic [1:0]           component,
    input  logic [3:0]           cell_i,
    input  logic [3:0]           cell_j,
    input  logic [3:0]           cell_k,
    input  logic signed [31:0]   face_value,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    output logic                 done,
    output logic signed [31:0]   vel_x,
    output logic signed [31:0]   vel_y,
    output logic signed [31:0]   vel_z,
    output logic                 saturated
);
    localparam int DEPTH = CELLS_X * CELLS_Y * CELLS_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(CELLS_X);
    localparam int YW    = $clog2(CELLS_Y);
    localparam int ZW    = $clog2(CELLS_Z);

    // configuration
    logic signed [31:0] org_x_reg, org_y_reg, org_z_reg;
    logic [23:0]        inv_x_reg, inv_y_reg, inv_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x_reg <= '0;
            org_y_reg <= '0;
            org_z_reg <= '0;
            inv_x_reg <= 24'h010000;
            inv_y_reg <= 24'h010000;
            inv_z_reg <= 24'h010000;
        end
        else if (cfg_en)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X: org_x_reg <= cfg_data;
                CFG_ORIGIN_Y: org_y_reg <= cfg_data;
                CFG_ORIGIN_Z: org_z_reg <= cfg_data;
                CFG_INV_X:    inv_x_reg <= cfg_data[23:0];
                CFG_INV_Y:    inv_y_reg <= cfg_data[23:0];
                CFG_INV_Z:    inv_z_reg <= cfg_data[23:0];
                default:      ;
            endcase
        end
    end

    // sequencer
    state_t     state_reg, state_next;
    logic [2:0] corner_reg, corner_next;
    logic       done_reg;
    logic       accept;
    lane_ctl_t  ctl;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            corner_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
            done_reg   <= (state_reg == S_Z);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        ctl         = '0;
        ctl.corner  = corner_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                corner_next = '0;
                if (accept && req_type == REQ_SAMPLE)
                    state_next = S_MUL;
            end
            S_MUL:  state_next = S_LAT;
            S_LAT:  state_next = S_RD;
            S_RD:
            begin
                ctl.rd      = 1'b1;
                corner_next = corner_reg + 3'd1;
                if (corner_reg == 3'd7)
                    state_next = S_WAIT;
            end
            S_WAIT: state_next = S_Y0;
            S_Y0:
            begin
                ctl.y0     = 1'b1;
                state_next = S_Y1;
            end
            S_Y1:
            begin
                ctl.y1     = 1'b1;
                state_next = S_Z;
            end
            S_Z:
            begin
                ctl.z      = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sample position held over the operation
    logic signed [31:0] px_reg, py_reg, pz_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
    end

    // per-axis lattice mapping; "full" is the own-axis lattice, "half" is shifted
    logic [XW-1:0] xlf, xhf, xlh, xhh;
    logic [YW-1:0] ylf, yhf, ylh, yhh;
    logic [ZW-1:0] zlf, zhf, zlh, zhh;
    logic [15:0]   xff, xfh, yff, yfh, zff, zfh;
    logic          sat_ax, sat_ay, sat_az;
    logic          mul_en, lat_en;

    assign mul_en = (state_reg == S_MUL);
    assign lat_en = (state_reg == S_LAT);

    mgts_axis_map #(.COUNT(CELLS_X)) u_map_x (
        .clk(clk), .mul_en(mul_en), .lat_en(lat_en),
        .pos(px_reg), .org(org_x_reg), .inv(inv_x_reg),
        .lo_full(xlf), .hi_full(xhf), .frac_full(xff),
        .lo_half(xlh), .hi_half(xhh), .frac_half(xfh), .sat(sat_ax)
    );

    mgts_axis_map #(.COUNT(CELLS_Y)) u_map_y (
        .clk(clk), .mul_en(mul_en), .lat_en(lat_en),
        .pos(py_reg), .org(org_y_reg), .inv(inv_y_reg),
        .lo_full(ylf), .hi_full(yhf), .frac_full(yff),
        .lo_half(ylh), .hi_half(yhh), .frac_half(yfh), .sat(sat_ay)
    );

    mgts_axis_map #(.COUNT(CELLS_Z)) u_map_z (
        .clk(clk), .mul_en(mul_en), .lat_en(lat_en),
        .pos(pz_reg), .org(org_z_reg), .inv(inv_z_reg),
        .lo_full(zlf), .hi_full(zhf), .frac_full(zff),
        .lo_half(zlh), .hi_half(zhh), .frac_half(zfh), .sat(sat_az)
    );

    // write index: 4-bit cell index reduced modulo the cell count
    function automatic logic [3:0] wrap4(logic [3:0] v, int n);
        logic [3:0] r;
        r = v;
        for (int s = 0; s < 8; s++)
        begin
            if (9'(r) >= 9'(n))
                r = 4'(9'(r) - 9'(n));
        end
        return r;
    endfunction

    logic [3:0]    wi, wj, wk;
    logic [AW-1:0] waddr;

    always_comb
    begin
        wi    = wrap4(cell_i, CELLS_X);
        wj    = wrap4(cell_j, CELLS_Y);
        wk    = wrap4(cell_k, CELLS_Z);
        waddr = AW'(wi) + AW'(CELLS_X) * (AW'(wj) + AW'(CELLS_Y) * AW'(wk));
    end

    logic signed [31:0] vel_lane [3];
    logic [2:0]         sat_lane;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [XW-1:0] ix;
        logic [YW-1:0] iy;
        logic [ZW-1:0] iz;
        logic [15:0]   fx, fy, fz;
        logic [AW-1:0] raddr;
        logic          we;

        // own axis uses the unshifted lattice, the other two the half-cell one
        always_comb
        begin
            if (k == 0)
            begin
                ix = corner_reg[0] ? xhf : xlf;
                fx = xff;
            end
            else
            begin
                ix = corner_reg[0] ? xhh : xlh;
                fx = xfh;
            end
            if (k == 1)
            begin
                iy = corner_reg[1] ? yhf : ylf;
                fy = yff;
            end
            else
            begin
                iy = corner_reg[1] ? yhh : ylh;
                fy = yfh;
            end
            if (k == 2)
            begin
                iz = corner_reg[2] ? zhf : zlf;
                fz = zff;
            end
            else
            begin
                iz = corner_reg[2] ? zhh : zlh;
                fz = zfh;
            end
            raddr = AW'(ix) + AW'(CELLS_X) * (AW'(iy) + AW'(CELLS_Y) * AW'(iz));
        end

        assign we = accept && (req_type == REQ_WRITE) && (component == 2'(k));

        mgts_comp_lane #(.DEPTH(DEPTH)) u_lane (
            .clk(clk), .rst_n(rst_n),
            .we(we), .waddr(waddr), .wdata(face_value),
            .raddr(raddr), .ctl(ctl),
            .fx(fx), .fy(fy), .fz(fz),
            .vel(vel_lane[k]), .sat(sat_lane[k])
        );
    end

    assign done      = done_reg;
    assign vel_x     = vel_lane[COMP_X];
    assign vel_y     = vel_lane[COMP_Y];
    assign vel_z     = vel_lane[COMP_Z];
    assign saturated = (|sat_lane) | sat_ax | sat_ay | sat_az;

endmodule

/* design/mgts_axis_map.sv */
// One axis: position to lattice coordinate, wrapped neighbour pair and fraction.
module mgts_axis_map
    import mgts_pkg::*;
#(
    parameter int COUNT = 16
) (
    input  logic                          clk,
    input  logic                          mul_en,
    input  logic                          lat_en,
    input  logic signed [31:0]            pos,
    input  logic signed [31:0]            org,
    input  logic [23:0]                   inv,
    output logic [$clog2(COUNT)-1:0]      lo_full,
    output logic [$clog2(COUNT)-1:0]      hi_full,
    output logic [15:0]                   frac_full,
    output logic [$clog2(COUNT)-1:0]      lo_half,
    output logic [$clog2(COUNT)-1:0]      hi_half,
    output logic [15:0]                   frac_half,
    output logic                          sat
);
    localparam int IW = $clog2(COUNT);

    logic signed [57:0] prod_reg;
    logic signed [32:0] delta;
    logic signed [41:0] lat_f;
    logic signed [41:0] lat_h;
    logic signed [31:0] c_f;
    logic signed [31:0] c_h;
    logic               s_f;
    logic               s_h;
    logic [IW-1:0]      lo_f;
    logic [IW-1:0]      lo_h;

    assign delta = 33'(pos) - 33'(org);

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= 58'(delta) * 58'($signed({1'b0, inv}));
        end
    end

    function automatic logic signed [31:0] clamp(logic signed [41:0] v);
        if (v > 42'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -42'sd2147483648)
            return 32'sh80000000;
        else
            return 32'(v);
    endfunction

    function automatic logic [IW-1:0] lower(logic signed [31:0] l);
        logic signed [15:0] b;
        b = 16'(l >>> 16);
        if (b < 0)
            return IW'(COUNT - 1);
        else if (17'(b) >= 17'sd0 + 17'(COUNT))
            return '0;
        else
            return b[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] upper(logic [IW-1:0] l);
        return (l == IW'(COUNT - 1)) ? '0 : l + 1'b1;
    endfunction

    always_comb
    begin
        lat_f = 42'(prod_reg >>> 16);
        lat_h = lat_f - 42'sd32768;
        c_f   = clamp(lat_f);
        c_h   = clamp(lat_h);
        s_f   = (lat_f > 42'sd2147483647) || (lat_f < -42'sd2147483648);
        s_h   = (lat_h > 42'sd2147483647) || (lat_h < -42'sd2147483648);
        lo_f  = lower(c_f);
        lo_h  = lower(c_h);
    end

    always_ff @(posedge clk)
    begin
        if (lat_en)
        begin
            lo_full   <= lo_f;
            hi_full   <= upper(lo_f);
            frac_full <= c_f[15:0];
            lo_half   <= lo_h;
            hi_half   <= upper(lo_h);
            frac_half <= c_h[15:0];
            sat       <= s_f | s_h;
        end
    end

endmodule

/* design/mgts_comp_lane.sv */
// One velocity component: face store memory and its own trilinear blend.
module mgts_comp_lane
    import mgts_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [31:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    input  lane_ctl_t                   ctl,
    input  logic [15:0]                 fx,
    input  logic [15:0]                 fy,
    input  logic [15:0]                 fz,
    output logic signed [31:0]          vel,
    output logic                        sat
);
    logic [31:0]        mem [DEPTH];
    logic [31:0]        rdata_reg;
    logic               rd_d_reg;
    logic [2:0]         corner_d_reg;
    logic signed [33:0] v0_reg;
    logic signed [33:0] row_reg [4];
    logic signed [33:0] col_reg [2];
    logic signed [33:0] cur;
    logic signed [33:0] fin;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_d_reg     <= 1'b0;
            corner_d_reg <= '0;
        end
        else
        begin
            rd_d_reg     <= ctl.rd;
            corner_d_reg <= ctl.corner;
        end
    end

    assign cur = 34'($signed(rdata_reg));
    assign fin = lerp(col_reg[0], col_reg[1], fz);

    always_ff @(posedge clk)
    begin
        if (rd_d_reg)
        begin
            if (!corner_d_reg[0])
                v0_reg <= cur;
            else
                row_reg[corner_d_reg[2:1]] <= lerp(v0_reg, cur, fx);
        end
        if (ctl.y0)
            col_reg[0] <= lerp(row_reg[0], row_reg[1], fy);
        if (ctl.y1)
            col_reg[1] <= lerp(row_reg[2], row_reg[3], fy);
        if (ctl.z)
        begin
            if (fin > 34'sd2147483647)
            begin
                vel <= 32'sh7fffffff;
                sat <= 1'b1;
            end
            else if (fin < -34'sd2147483648)
            begin
                vel <= 32'sh80000000;
                sat <= 1'b1;
            end
            else
            begin
                vel <= 32'(fin);
                sat <= 1'b0;
            end
        end
    end

endmodule

/* design/mgts_checker.sv */
// Port-level checks of the sampler's command handshake, bound to the top level.
module mgts_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic req_type,
    input logic done
);
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done longer than one cycle");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type) |=> busy)
        else $error("sample accepted without going busy");

    a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !req_type) |=> (!busy && !done))
        else $error("write produced activity");
endmodule

bind mac_grid_trilinear_sampler mgts_checker u_mgts_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .req_type(req_type), .done(done)
);

/* dv/mac_grid_trilinear_sampler_tb.sv */
// Testbench for the staggered-grid trilinear sampler: queue-fed driver, scoreboard monitor.
module mac_grid_trilinear_sampler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mgts_pkg::*;

    localparam int NX = 16;
    localparam int NY = 16;
    localparam int NZ = 16;
    localparam int NCELL = NX * NY * NZ;
    localparam int HALF = 32768;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 24;   // longer than a sample takes from accept to result

    typedef struct {
        logic [0:0]         req;
        logic [1:0]         comp;
        logic [3:0]         ci;
        logic [3:0]         cj;
        logic [3:0]         ck;
        logic signed [31:0] val;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } word_t;

    typedef struct {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic               sat;
    } vel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_en = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic start = 1'b0;
    logic busy;
    logic req_type = 1'b0;
    logic [1:0] component = '0;
    logic [3:0] cell_i = '0;
    logic [3:0] cell_j = '0;
    logic [3:0] cell_k = '0;
    logic signed [31:0] face_value = '0;
    logic signed [31:0] pos_x = '0;
    logic signed [31:0] pos_y = '0;
    logic signed [31:0] pos_z = '0;
    logic done;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic saturated;

    mac_grid_trilinear_sampler dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_en(cfg_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .req_type(req_type), .component(component),
        .cell_i(cell_i), .cell_j(cell_j), .cell_k(cell_k),
        .face_value(face_value), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .done(done), .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .saturated(saturated)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Mirror of the face stores and the grid registers
    // ---------------------------------------------------------------
    int     face_x_mem [NCELL];
    int     face_y_mem [NCELL];
    int     face_z_mem [NCELL];
    bit     loaded_x [NCELL];
    bit     loaded_y [NCELL];
    bit     loaded_z [NCELL];
    longint org_x = 0, org_y = 0, org_z = 0;
    longint inv_x = 65536, inv_y = 65536, inv_z = 65536;

    word_t  word_q[$];      // words waiting for the driver
    vel_t   velocity_q[$];  // predicted velocities not yet seen on the outputs
    int     fail_cnt = 0;
    int     writes_taken = 0;
    int     samples_taken = 0;
    int     sat_seen = 0;
    bit     gaps_on = 1'b1;

    function automatic longint clip32(longint v, ref bit sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    // Lattice mapping on one axis: lower/upper neighbor with periodic wrap, Q0.16 weight.
    task automatic map_axis(input longint pos, input longint org, input longint inv,
                            input int count, input bit half, ref bit sat,
                            output int lo, output int hi, output longint frac);
        longint lat;
        longint base;
        lat = ((pos - org) * inv) >>> 16;
        if (half)
            lat = lat - HALF;
        lat = clip32(lat, sat);
        base = lat >>> 16;
        frac = lat & 64'hFFFF;
        if (base < 0)
            lo = count - 1;        // below the grid: last cell
        else if (base >= count)
            lo = 0;                // past the grid: first cell
        else
            lo = int'(base);
        hi = (lo + 1 == count) ? 0 : lo + 1;
    endtask

    function automatic longint mix(longint a, longint b, longint f);
        return (a * (65536 - f) + b * f + HALF) >>> 16;
    endfunction

    function automatic longint fetch(int comp, int idx);
        case (comp)
            0: return longint'(face_x_mem[idx]);
            1: return longint'(face_y_mem[idx]);
            default: return longint'(face_z_mem[idx]);
        endcase
    endfunction

    task automatic interp_component(input int comp, input longint px, input longint py,
                                    input longint pz, ref bit sat, output longint res);
        int ilo, ihi, jlo, jhi, klo, khi;
        longint fx, fy, fz;
        longint r00, r01, r10, r11, c0, c1;
        int js[2];
        int ks[2];
        map_axis(px, org_x, inv_x, NX, comp != 0, sat, ilo, ihi, fx);
        map_axis(py, org_y, inv_y, NY, comp != 1, sat, jlo, jhi, fy);
        map_axis(pz, org_z, inv_z, NZ, comp != 2, sat, klo, khi, fz);
        js[0] = jlo; js[1] = jhi;
        ks[0] = klo; ks[1] = khi;
        r00 = mix(fetch(comp, ilo + NX * (js[0] + NY * ks[0])),
                  fetch(comp, ihi + NX * (js[0] + NY * ks[0])), fx);
        r01 = mix(fetch(comp, ilo + NX * (js[1] + NY * ks[0])),
                  fetch(comp, ihi + NX * (js[1] + NY * ks[0])), fx);
        r10 = mix(fetch(comp, ilo + NX * (js[0] + NY * ks[1])),
                  fetch(comp, ihi + NX * (js[0] + NY * ks[1])), fx);
        r11 = mix(fetch(comp, ilo + NX * (js[1] + NY * ks[1])),
                  fetch(comp, ihi + NX * (js[1] + NY * ks[1])), fx);
        c0 = mix(r00, r01, fy);
        c1 = mix(r10, r11, fy);
        res = clip32(mix(c0, c1, fz), sat);
    endtask

    // Apply one accepted word to the mirror; samples queue a predicted velocity.
    task automatic apply_word(input word_t w);
        int idx;
        bit sat;
        longint vx, vy, vz;
        vel_t v;
        if (w.req == REQ_WRITE)
        begin
            idx = int'(w.ci) + NX * (int'(w.cj) + NY * int'(w.ck));
            writes_taken++;
            case (w.comp)
                COMP_X:
                begin
                    face_x_mem[idx] = w.val;
                    loaded_x[idx] = 1'b1;
                end
                COMP_Y:
                begin
                    face_y_mem[idx] = w.val;
                    loaded_y[idx] = 1'b1;
                end
                COMP_Z:
                begin
                    face_z_mem[idx] = w.val;
                    loaded_z[idx] = 1'b1;
                end
                default: ;          // component 3: dropped
            endcase
        end
        else
        begin
            sat = 1'b0;
            interp_component(0, w.px, w.py, w.pz, sat, vx);
            interp_component(1, w.px, w.py, w.pz, sat, vy);
            interp_component(2, w.px, w.py, w.pz, sat, vz);
            v.vx = vx[31:0];
            v.vy = vy[31:0];
            v.vz = vz[31:0];
            v.sat = sat;
            velocity_q = {velocity_q, v};
            samples_taken++;
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: pops words, holds start until taken, inserts random gaps
    // ---------------------------------------------------------------
    int  gap_left = 0;
    word_t cur;
    wire take = start && !busy;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (take)
                apply_word(cur);
            if (start && !take)
                ;                   // word still pending, hold everything
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (word_q.size() > 0)
            begin
                cur = word_q.pop_front();
                start <= 1'b1;
                req_type <= cur.req;
                component <= cur.comp;
                cell_i <= cur.ci;
                cell_j <= cur.cj;
                cell_k <= cur.ck;
                face_value <= cur.val;
                pos_x <= cur.px;
                pos_y <= cur.py;
                pos_z <= cur.pz;
                if (!gaps_on || $urandom_range(0, 99) < 55)
                    gap_left <= 0;
                else if ($urandom_range(0, 99) < 92)
                    gap_left <= $urandom_range(1, 4);
                else
                    gap_left <= $urandom_range(20, 70);
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every done pulse is checked against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        vel_t e;
        if (rst_n && done)
        begin
            if (velocity_q.size() == 0)
            begin
                $error("velocity word with no sample pending");
                fail_cnt++;
            end
            else
            begin
                e = velocity_q.pop_front();
                if (vel_x !== e.vx)
                begin
                    $error("vel_x expected %0d actual %0d", e.vx, vel_x);
                    fail_cnt++;
                end
                if (vel_y !== e.vy)
                begin
                    $error("vel_y expected %0d actual %0d", e.vy, vel_y);
                    fail_cnt++;
                end
                if (vel_z !== e.vz)
                begin
                    $error("vel_z expected %0d actual %0d", e.vz, vel_z);
                    fail_cnt++;
                end
                if (saturated !== e.sat)
                begin
                    $error("saturated expected %0b actual %0b", e.sat, saturated);
                    fail_cnt++;
                end
                if (e.sat)
                    sat_seen++;
            end
        end
    end

    // Watchdog: too long with no word, no velocity and no register write.
    int quiet = 0;
    always @(posedge clk)
    begin
        if (take || done || cfg_en || !rst_n)
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic word_t write_word(int comp, int i, int j, int k, int val);
        word_t w;
        w = '{default: '0};
        w.req = REQ_WRITE;
        w.comp = comp[1:0];
        w.ci = i[3:0];
        w.cj = j[3:0];
        w.ck = k[3:0];
        w.val = val;
        w.px = $urandom;            // don't-care fields still toggle
        w.py = $urandom;
        w.pz = $urandom;
        return w;
    endfunction

    function automatic word_t sample_word(int x, int y, int z);
        word_t w;
        w.req = REQ_SAMPLE;
        w.comp = 2'($urandom_range(0, 3));
        w.ci = 4'($urandom);
        w.cj = 4'($urandom);
        w.ck = 4'($urandom);
        w.val = $urandom;
        w.px = x;
        w.py = y;
        w.pz = z;
        return w;
    endfunction

    // Lower neighbor of one axis under the current grid settings.
    function automatic int cell_lo(longint pos, longint org, longint inv, int count, bit half);
        longint lat;
        longint base;
        lat = ((pos - org) * inv) >>> 16;
        if (half)
            lat = lat - HALF;
        if (lat > 64'sd2147483647)
            lat = 64'sd2147483647;
        if (lat < -64'sd2147483648)
            lat = -64'sd2147483648;
        base = lat >>> 16;
        if (base < 0)
            return count - 1;
        if (base >= count)
            return 0;
        return int'(base);
    endfunction

    function automatic bit is_loaded(int comp, int idx);
        case (comp)
            0: return loaded_x[idx];
            1: return loaded_y[idx];
            default: return loaded_z[idx];
        endcase
    endfunction

    // True when every corner that the sample reads in all three stores holds a value.
    function automatic bit corners_ok(longint px, longint py, longint pz);
        int ia[2];
        int ja[2];
        int ka[2];
        for (int c = 0; c < 3; c++)
        begin
            ia[0] = cell_lo(px, org_x, inv_x, NX, c != 0);
            ja[0] = cell_lo(py, org_y, inv_y, NY, c != 1);
            ka[0] = cell_lo(pz, org_z, inv_z, NZ, c != 2);
            ia[1] = (ia[0] + 1 == NX) ? 0 : ia[0] + 1;
            ja[1] = (ja[0] + 1 == NY) ? 0 : ja[0] + 1;
            ka[1] = (ka[0] + 1 == NZ) ? 0 : ka[0] + 1;
            for (int n = 0; n < 8; n++)
            begin
                if (!is_loaded(c, ia[n % 2] + NX * (ja[(n / 2) % 2] + NY * ka[n / 4])))
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Position near the lower corner or around the upper wrap, scaled to the spacing.
    function automatic int near_grid(longint org, longint inv);
        longint span;
        longint step;
        longint p;
        span = (inv == 0) ? (64'sd1 <<< 36) : ((64'sd1 <<< 32) / inv);
        if ($urandom_range(0, 1) == 0)
            step = longint'($urandom_range(0, 4)) - 3;
        else
            step = longint'($urandom_range(14, 18));
        p = org + step * span + ((longint'($urandom_range(0, 65535)) * span) >>> 16);
        if (p > 64'sd2147483647)
            p = 64'sd2147483647;
        if (p < -64'sd2147483648)
            p = -64'sd2147483648;
        return int'(p);
    endfunction

    function automatic int rand_value();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 131071) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic word_t rand_word();
        int x;
        int y;
        int z;
        if ($urandom_range(0, 99) < 25)
            return write_word($urandom_range(0, 3), $urandom_range(0, 15),
                              $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
        for (int t = 0; t < 40; t++)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                x = $urandom;
                y = $urandom;
                z = $urandom;
            end
            else
            begin
                x = near_grid(org_x, inv_x);
                y = near_grid(org_y, inv_y);
                z = near_grid(org_z, inv_z);
            end
            if (corners_ok(x, y, z))
                return sample_word(x, y, z);
        end
        // no position with loaded corners found: send a write instead
        return write_word($urandom_range(0, 3), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15), rand_value());
    endfunction

    task automatic drain();
        while (word_q.size() > 0 || start || velocity_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IW-1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ORIGIN_X: org_x = longint'(signed'(data));
            CFG_ORIGIN_Y: org_y = longint'(signed'(data));
            CFG_ORIGIN_Z: org_z = longint'(signed'(data));
            CFG_INV_X:    inv_x = longint'(data[23:0]);
            CFG_INV_Y:    inv_y = longint'(data[23:0]);
            CFG_INV_Z:    inv_z = longint'(data[23:0]);
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [31:0] ox, input logic [31:0] oy, input logic [31:0] oz,
                            input logic [31:0] ix, input logic [31:0] iy, input logic [31:0] iz);
        set_reg(CFG_ORIGIN_X, ox);
        set_reg(CFG_ORIGIN_Y, oy);
        set_reg(CFG_ORIGIN_Z, oz);
        set_reg(CFG_INV_X, ix);
        set_reg(CFG_INV_Y, iy);
        set_reg(CFG_INV_Z, iz);
        set_reg(3'd6, $urandom);    // unused indexes must be ignored
        set_reg(3'd7, $urandom);
        @(posedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic random_phase(input int n);
        repeat (n) word_q = {word_q, rand_word()};
        drain();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        int load_cells[4];
        load_cells = '{15, 0, 1, 2};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Load the cells around the periodic seam (indexes 15, 0, 1, 2) of all three stores.
        gaps_on = 1'b0;
        for (int c = 0; c < 3; c++)
            for (int a = 0; a < 64; a++)
                word_q = {word_q, write_word(c, load_cells[a % 4], load_cells[(a / 4) % 4],
                                             load_cells[a / 16], rand_value())};
        drain();
        gaps_on = 1'b1;

        // Directed: value and index extremes, ignored component, edge positions.
        word_q = {word_q, write_word(COMP_X, 0, 0, 0, 32'sh7FFFFFFF)};
        word_q = {word_q, write_word(COMP_X, 15, 15, 15, 32'sh80000000)};
        word_q = {word_q, write_word(COMP_Y, 15, 0, 15, 32'sh80000000)};
        word_q = {word_q, write_word(COMP_Z, 0, 15, 0, 32'sh7FFFFFFF)};
        word_q = {word_q, write_word(3, 5, 5, 5, 32'sh12345678)};
        word_q = {word_q, sample_word(0, 0, 0)};
        word_q = {word_q, sample_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF)};
        word_q = {word_q, sample_word(32'sh80000000, 32'sh80000000, 32'sh80000000)};
        word_q = {word_q, sample_word(32'sh00008000, 32'sh00008000, 32'sh00008000)};
        word_q = {word_q, sample_word(-32'sh10000, 32'sh100000, -32'sh8000)};   // below / past
        word_q = {word_q, sample_word(32'sh000F8000, 32'sh000FFFFF, 32'sh00100000)}; // wrap
        word_q = {word_q, sample_word(32'sh00104000, -32'sh1, 32'sh0001C000)};
        word_q = {word_q, sample_word(32'sh5, 32'sh5, 32'sh5)};
        drain();

        // With nothing in flight here, a mixed stretch on reset settings.
        random_phase(180);

        // Extreme origins with the largest inverse spacing.
        set_grid(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF);
        random_phase(130);

        // Zero inverse spacing on all axes: only the half-cell offset is left.
        set_grid($urandom, $urandom, $urandom, 32'h0, 32'h0, 32'h0);
        word_q = {word_q, sample_word($urandom, $urandom, $urandom)};
        random_phase(60);

        // Fine spacing and mixed spacings.
        set_grid(32'hFFF80000, 32'h00040000, 32'hFFFFC000, 32'h1, 32'h40000, 32'h8000);
        random_phase(130);

        for (int p = 0; p < 4; p++)
        begin
            set_grid($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 21) - (1 << 20),
                     $urandom_range(0, 1 << 21) - (1 << 20), $urandom,
                     $urandom_range(1 << 14, 1 << 20), $urandom_range(0, 24'hFFFFFF),
                     $urandom_range(1 << 12, 1 << 18));
            random_phase(110);
        end

        drain();
        $display("Covered %0d writes and %0d samples (%0d saturated) over 8 grid settings",
                 writes_taken, samples_taken, sat_seen);
        $display("including seam-region store loads, ignored component writes and wrapped lattices.");
        if (fail_cnt == 0 && velocity_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
design/mgts_pkg.sv
design/mgts_axis_map.sv
design/mgts_comp_lane.sv
design/mac_grid_trilinear_sampler.sv
design/mgts_checker.sv
dv/mac_grid_trilinear_sampler_tb.sv
